@@ rtl/sensor_frame_parser_with_checksum_unit_defines.svh @@
// Assertion macros for the frame parser.
`ifndef SENSOR_FRAME_PARSER_WITH_CHECKSUM_UNIT_DEFINES_SVH
`define SENSOR_FRAME_PARSER_WITH_CHECKSUM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFPC_ASSERT_IMP(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFPC_ASSERT_NXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sfpc_pkg.sv @@
`timescale 1ns / 1ps
package sfpc_pkg;

  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned PpmWidth    = 16;
  localparam int unsigned PosWidth    = 4;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = 8;

  localparam logic [ByteWidth-1:0] StartByteReset   = 8'hFF;
  localparam logic [ByteWidth-1:0] CommandByteReset = 8'h86;

  localparam logic [PosWidth-1:0] FirstDataPos = 4'd2;
  localparam logic [PosWidth-1:0] LowDataPos   = 4'd3;
  localparam logic [PosWidth-1:0] LastPos      = 4'd8;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_START   = 3'b010,
    PH_COLLECT = 3'b100
  } phase_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_START_BYTE   = 2'd0,
    REG_COMMAND_BYTE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    phase_t              phase;
    logic [PosWidth-1:0] pos;
    logic                step;
    logic                emit;
  } sfpc_status_t;

endpackage

@@ rtl/sfpc_if.sv @@
`timescale 1ns / 1ps
interface sfpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfpc_out_if;
  logic        valid;
  logic        ready;
  logic        frame_status;
  logic [15:0] co2_ppm;
  logic [7:0]  computed_checksum;

  modport source (output valid, output frame_status, output co2_ppm,
                  output computed_checksum, input ready);
  modport sink (input valid, input frame_status, input co2_ppm,
                input computed_checksum, output ready);
endinterface

@@ rtl/sfpc_in_reg.sv @@
`timescale 1ns / 1ps
module sfpc_in_reg
  import sfpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  sfpc_in_if.sink              rx,
  input  logic                 take,
  output logic                 data_valid,
  output logic [ByteWidth-1:0] data
);

  assign rx.ready = !data_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
    end else if (rx.ready) begin
      data_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      data <= rx.rx_byte;
    end
  end

endmodule

@@ rtl/sfpc_parser.sv @@
`timescale 1ns / 1ps
module sfpc_parser
  import sfpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   data_valid,
  input  logic [ByteWidth-1:0]   data,
  input  logic                   slot_free,
  output logic                   take,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_data,
  output logic                   emit,
  output logic                   emit_status,
  output logic [PpmWidth-1:0]    emit_ppm,
  output logic [ByteWidth-1:0]   emit_checksum,
  output sfpc_status_t           status
);

  logic [ByteWidth-1:0] start_byte;
  logic [ByteWidth-1:0] command_byte;

  phase_t               phase, phase_next;
  logic [PosWidth-1:0]  pos, pos_next;
  logic [ByteWidth-1:0] running_sum, running_sum_next;
  logic [ByteWidth-1:0] reading_high, reading_high_next;
  logic [ByteWidth-1:0] reading_low, reading_low_next;
  logic                 step;
  logic                 frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte   <= StartByteReset;
      command_byte <= CommandByteReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_BYTE:   start_byte   <= cfg_data;
        REG_COMMAND_BYTE: command_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  assign step      = data_valid && slot_free;
  assign take      = step;
  assign frame_end = (phase == PH_COLLECT) && (pos >= LastPos);
  assign emit      = step && frame_end;

  assign emit_checksum = ByteWidth'(8'h00 - running_sum);
  assign emit_status   = (emit_checksum != data);
  assign emit_ppm      = {reading_high, reading_low};

  always_comb begin
    phase_next        = phase;
    pos_next          = pos;
    running_sum_next  = running_sum;
    reading_high_next = reading_high;
    reading_low_next  = reading_low;
    unique case (phase)
      PH_START: begin
        if (data == command_byte) begin
          phase_next       = PH_COLLECT;
          pos_next         = FirstDataPos;
          running_sum_next = data;
        end else begin
          phase_next = PH_IDLE;
          pos_next   = '0;
        end
      end
      PH_COLLECT: begin
        if (frame_end) begin
          phase_next = PH_IDLE;
          pos_next   = '0;
        end else begin
          if (pos == FirstDataPos) reading_high_next = data;
          if (pos == LowDataPos) reading_low_next = data;
          running_sum_next = running_sum + data;
          pos_next         = pos + PosWidth'(1);
        end
      end
      default: begin
        // idle: only the start byte opens a frame
        if (data == start_byte) begin
          phase_next = PH_START;
          pos_next   = PosWidth'(1);
        end else begin
          phase_next = PH_IDLE;
          pos_next   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pos   <= '0;
    end else if (step) begin
      phase <= phase_next;
      pos   <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      running_sum  <= running_sum_next;
      reading_high <= reading_high_next;
      reading_low  <= reading_low_next;
    end
  end

  assign status = '{phase: phase, pos: pos, step: step, emit: emit};

endmodule

@@ rtl/sfpc_out_reg.sv @@
`timescale 1ns / 1ps
module sfpc_out_reg
  import sfpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 load_status,
  input  logic [PpmWidth-1:0]  load_ppm,
  input  logic [ByteWidth-1:0] load_checksum,
  output logic                 slot_free,
  sfpc_out_if.source           res
);

  assign slot_free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (slot_free) begin
      res.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && slot_free) begin
      res.frame_status      <= load_status;
      res.co2_ppm           <= load_ppm;
      res.computed_checksum <= load_checksum;
    end
  end

endmodule

@@ rtl/sensor_frame_parser_with_checksum_unit.sv @@
`timescale 1ns / 1ps
// Flow: a byte is registered on acceptance and parsed once the output register
//   is free; the result is registered when the checksum byte is parsed.
// Throughput: one byte per cycle while the output register can take a result.
// Reset (rst, synchronous): parser idle, in/out stages empty, start byte 0xFF,
//   command byte 0x86.
`include "sensor_frame_parser_with_checksum_unit_defines.svh"
module sensor_frame_parser_with_checksum_unit
  import sfpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  sfpc_in_if.sink                rx,
  sfpc_out_if.source             res,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_data
);

  logic                 data_valid;
  logic [ByteWidth-1:0] data;
  logic                 take;
  logic                 slot_free;
  logic                 emit;
  logic                 emit_status;
  logic [PpmWidth-1:0]  emit_ppm;
  logic [ByteWidth-1:0] emit_checksum;
  sfpc_status_t         status;

  sfpc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .take       (take),
    .data_valid (data_valid),
    .data       (data)
  );

  sfpc_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data          (data),
    .slot_free     (slot_free),
    .take          (take),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .emit          (emit),
    .emit_status   (emit_status),
    .emit_ppm      (emit_ppm),
    .emit_checksum (emit_checksum),
    .status        (status)
  );

  sfpc_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (emit),
    .load_status   (emit_status),
    .load_ppm      (emit_ppm),
    .load_checksum (emit_checksum),
    .slot_free     (slot_free),
    .res           (res)
  );

  // a finished frame always drops back to idle
  `SFPC_ASSERT_NXT(a_emit_then_idle, clk, rst, status.emit, status.phase == PH_IDLE, "parser not idle after frame end")
  // collecting stays within data and checksum positions
  `SFPC_ASSERT_IMP(a_collect_pos, clk, rst, status.phase == PH_COLLECT, (status.pos >= FirstDataPos) && (status.pos <= LastPos), "collect position out of range")
  // never overwrite a result still waiting downstream
  `SFPC_ASSERT_IMP(a_no_overwrite, clk, rst, status.emit, !res.valid || res.ready, "result emitted into a full output register")
  // a result only comes from a consumed byte
  `SFPC_ASSERT_IMP(a_emit_needs_byte, clk, rst, status.emit, status.step && data_valid, "result without a parsed byte")

endmodule
